/* rtl/softmax_vector_activation_core_macros.svh */
// Assertion macros for the softmax vector activation core.
// Included by the top level; no other dependencies.
`ifndef SOFTMAX_VECTOR_ACTIVATION_CORE_MACROS_SVH
`define SOFTMAX_VECTOR_ACTIVATION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SMX_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SMX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SMX_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SMX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/smx_pkg.sv */
// Shared types and constants for the softmax vector activation core.
// No dependencies.
package smx_pkg;
  localparam int MaxElements = 64;
  localparam int AddrW = $clog2(MaxElements);
  localparam int CntW = $clog2(MaxElements + 1);
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  // Front-to-back queue entry: one element, with a flag set on the element that closes its vector.
  typedef struct packed {
    logic signed [15:0] score;
    logic               close;
  } smx_entry_t;

  typedef struct packed {
    logic busy;
    logic idle;
  } smx_status_t;

  // round(2^24 * exp(-2^(b-8))) for each bit of the Q8.8 difference.
  function automatic logic [23:0] exp_k(input logic [3:0] b);
    logic [23:0] k;
    case (b)
      4'd0: k = 24'd16711808;
      4'd1: k = 24'd16646655;
      4'd2: k = 24'd16517109;
      4'd3: k = 24'd16261035;
      4'd4: k = 24'd15760736;
      4'd5: k = 24'd14805841;
      4'd6: k = 24'd13066109;
      4'd7: k = 24'd10175896;
      4'd8: k = 24'd6171993;
      4'd9: k = 24'd2270549;
      4'd10: k = 24'd307285;
      4'd11: k = 24'd5628;
      4'd12: k = 24'd2;
      default: k = 24'd0;
    endcase
    return k;
  endfunction
endpackage

/* rtl/softmax_vector_activation_core.sv */
// Softmax vector activation core: front end, queue and back end.
// Depends on smx_pkg, smx_front, smx_queue, smx_back and the macros header.
// Scores are taken one per start pulse while busy is low; a vector closes on
// in_is_last or on its 64th element. Results come out one per out_valid
// pulse and cannot be stalled. After the close each element's exponential is
// taken in the bit-serial exponential unit and summed, then each is divided by
// the sum in the shift-subtract divider; the next vector's scores are drained
// from the queue only after the vector's last result has been emitted.
`include "softmax_vector_activation_core_macros.svh"
module softmax_vector_activation_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_score,
  input  logic               in_is_last,
  output logic               out_valid,
  output logic [15:0]        out_probability,
  output logic               out_end_of_vector
);
  import smx_pkg::*;

  smx_entry_t  push_data, pop_data;
  smx_status_t status;
  logic        accept, push, pop, q_empty, q_full, front_busy;

  assign accept = start && !busy;
  assign busy = front_busy;

  smx_front u_front (
    .clk, .rst_n, .in_accept(accept), .in_score, .in_is_last,
    .q_full, .q_push(push), .q_data(push_data), .front_busy
  );

  smx_queue u_queue (
    .clk, .rst_n, .push, .push_data, .pop, .pop_data,
    .empty(q_empty), .full(q_full)
  );

  smx_back u_back (
    .clk, .rst_n, .q_empty, .q_data(pop_data), .q_pop(pop),
    .out_probability, .out_end_of_vector, .out_valid, .status
  );

  `SMX_ASSERT_IMPL(a_no_push_full, clk, rst_n, q_full, !push, "push into full queue")
  `SMX_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, pop, !q_empty, "pop from empty queue")
  `SMX_ASSERT_IMPL(a_idle_quiet, clk, rst_n, status.idle, !out_valid || out_end_of_vector, "emit while idle")
endmodule

/* rtl/smx_front.sv */
// Front end: accepts scores, closes a vector on is_last or full store.
// Depends on smx_pkg.
module smx_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic signed [15:0]  in_score,
  input  logic                in_is_last,
  input  logic                q_full,
  output logic                q_push,
  output smx_pkg::smx_entry_t q_data,
  output logic                front_busy
);
  import smx_pkg::*;

  logic [CntW-1:0] count_r, count_nxt;
  logic            close_w;

  // The element that fills the store also closes the vector.
  assign close_w = in_is_last || (count_r == CntW'(MaxElements - 1));
  assign q_push = in_accept;
  assign q_data = '{score: in_score, close: close_w};
  assign front_busy = q_full;
  assign count_nxt = !in_accept ? count_r : (close_w ? '0 : count_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else count_r <= count_nxt;
  end
endmodule

/* rtl/smx_queue.sv */
// Short FIFO between front and back end.
// Depends on smx_pkg.
module smx_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  smx_pkg::smx_entry_t push_data,
  input  logic                pop,
  output smx_pkg::smx_entry_t pop_data,
  output logic                empty,
  output logic                full
);
  import smx_pkg::*;

  smx_entry_t       mem_r [QDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0]   cnt_r;

  assign empty = (cnt_r == '0);
  assign full = (cnt_r == (QPtrW+1)'(QDepth));
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end
endmodule

/* rtl/smx_back.sv */
// Back end: stores a vector, then exp/sum pass and a normalizing divide pass.
// Depends on smx_pkg.
module smx_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  smx_pkg::smx_entry_t q_data,
  output logic                q_pop,
  output logic [15:0]         out_probability,
  output logic                out_end_of_vector,
  output logic                out_valid,
  output smx_pkg::smx_status_t status
);
  import smx_pkg::*;

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001, S_ERD  = 6'b000010, S_EXP  = 6'b000100,
    S_PRD  = 6'b001000, S_DIV  = 6'b010000, S_EMIT = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic signed [15:0] store_mem [MaxElements];
  logic [24:0]       exp_mem [MaxElements];
  logic signed [15:0] rd_score_r;
  logic [24:0]       rd_exp_r;
  logic [CntW-1:0]   n_r;
  logic [AddrW-1:0]  idx_r;
  logic signed [15:0] max_r;
  logic [30:0]       sum_r;
  logic [15:0]       d_r;
  logic [24:0]       e_r;
  logic [24:0]       e_fin;
  logic [3:0]        bit_r;
  logic [40:0]       rem_r;
  logic [16:0]       num_r;
  logic [16:0]       quo_r;
  logic [5:0]        dstep_r;
  logic [48:0]       prod;
  logic [46:0]       num;
  logic [41:0]       trial;
  logic              last_idx;

  assign q_pop = (state_r == S_LOAD) && !q_empty;
  assign last_idx = (CntW'(idx_r) + 1'b1 == n_r);
  assign status.busy = (state_r != S_LOAD);
  assign status.idle = (state_r == S_LOAD) && q_empty;
  // Q1.24 exponential, 1.0 = 2^24; one rounded constant multiply per bit
  assign prod = e_r * exp_k(bit_r);
  assign e_fin = d_r[0] ? 25'((prod + 49'd8388608) >> 24) : e_r;
  // Dividend e * 2^16 + floor(S / 2)
  assign num = {6'd0, rd_exp_r, 16'd0} + 47'(sum_r >> 1);
  assign trial = {rem_r, num_r[16]} - {11'd0, sum_r};

  // Store write and registered reads
  always_ff @(posedge clk) begin
    if (q_pop) store_mem[n_r[AddrW-1:0]] <= q_data.score;
    rd_score_r <= store_mem[idx_r];
    rd_exp_r <= exp_mem[idx_r];
    if (state_r == S_EXP && bit_r == 4'd15) exp_mem[idx_r] <= e_fin;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: if (q_pop && q_data.close) state_nxt = S_ERD;
      S_ERD:  state_nxt = S_EXP;
      S_EXP:  if (bit_r == 4'd15) state_nxt = last_idx ? S_PRD : S_ERD;
      S_PRD:  state_nxt = S_DIV;
      S_DIV:  if (dstep_r == 6'd17) state_nxt = S_EMIT;
      S_EMIT: state_nxt = last_idx ? S_LOAD : S_PRD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; n_r <= '0; idx_r <= '0; max_r <= 16'sh8000;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == S_EMIT);
      case (state_r)
        S_LOAD: if (q_pop) begin
          n_r <= n_r + 1'b1;
          if (q_data.score > max_r) max_r <= q_data.score;
          idx_r <= '0;
        end
        S_EXP: if (bit_r == 4'd15) idx_r <= last_idx ? '0 : idx_r + 1'b1;
        S_EMIT: if (last_idx) begin
          n_r <= '0; idx_r <= '0; max_r <= 16'sh8000;
        end else idx_r <= idx_r + 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath: bit-serial exp (one constant multiply per cycle), restoring divide
  always_ff @(posedge clk) begin
    case (state_r)
      S_LOAD: sum_r <= '0;
      S_ERD: begin
        bit_r <= '0; e_r <= 25'h1000000; d_r <= '0;
      end
      S_EXP: begin
        if (bit_r == 4'd0) begin
          d_r <= 16'(max_r - rd_score_r) >> 1;
          e_r <= (16'(max_r - rd_score_r) & 16'd1) != 0 ? 25'(exp_k(4'd0))
                                                         : 25'h1000000;
        end else begin
          d_r <= d_r >> 1;
          e_r <= e_fin;
        end
        bit_r <= bit_r + 1'b1;
        if (bit_r == 4'd15) sum_r <= sum_r + 31'(e_fin);
      end
      S_PRD: dstep_r <= '0;
      S_DIV: begin
        // top of the dividend is below S, so 17 quotient bits cover it
        if (dstep_r == 6'd0) begin
          rem_r <= 41'(num[46:17]);
          num_r <= num[16:0];
          quo_r <= '0;
        end else begin
          if (!trial[41]) begin
            rem_r <= trial[40:0]; quo_r <= {quo_r[15:0], 1'b1};
          end else begin
            rem_r <= {rem_r[39:0], num_r[16]}; quo_r <= {quo_r[15:0], 1'b0};
          end
          num_r <= {num_r[15:0], 1'b0};
        end
        dstep_r <= dstep_r + 1'b1;
      end
      S_EMIT: begin
        out_probability <= quo_r[16] ? 16'hFFFF : quo_r[15:0];
        out_end_of_vector <= last_idx;
      end
      default: ;
    endcase
  end
endmodule
